// ----- hdl/hall_position_speed_counter_macros.svh -----
// Assertion macros for the hall position and speed counter.
// Included by the top level; no other dependencies.
`ifndef HALL_POSITION_SPEED_COUNTER_MACROS_SVH
`define HALL_POSITION_SPEED_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define HPSC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("hpsc assertion failed");
// expression must never be true outside reset
`define HPSC_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("hpsc forbidden condition seen");
`else
`define HPSC_ASSERT(lbl, clk, rstn, prop)
`define HPSC_NEVER(lbl, clk, rstn, expr)
`endif
`endif

// ----- hdl/hpsc_pkg.sv -----
// Shared types, constants and hall decode functions for the hall counter.
// No dependencies; imported by the controller, datapath and top level.
package hpsc_pkg;

    localparam int unsigned TPR_W     = 12;
    localparam int unsigned TICK_W    = 32;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned SPEED_W   = 21;
    localparam int unsigned NUM_W     = 50;   // |delta| * 256000
    localparam int unsigned DEN_W     = 44;   // ticks_per_rotation * elapsed
    localparam int unsigned QUO_W     = 20;   // quotient bits below saturation
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [TPR_W-1:0]   TPR_RESET    = 12'd90;
    localparam logic [17:0]        Q8_MS_SCALE  = 18'd256000;
    localparam logic [SPEED_W-1:0] SPEED_POS_SAT = 21'h0F_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_SAT = 21'h10_0000;
    localparam logic [CNT_W-1:0]   DIV_LAST_BIT  = 5'd19;

    localparam logic [2:0] HALL_INVALID_LO = 3'd0;
    localparam logic [2:0] HALL_INVALID_HI = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_TEST,
        ST_MUL,
        ST_SAT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic cfg_wr;
        logic load;
        logic step;
        logic mul;
        logic sat;
        logic div;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic need_speed;
        logic ovf;
        logic div_last;
    } t_dp_status;

    typedef struct packed {
        logic       valid;
        logic [2:0] pos;
    } t_hall_pos;

    // order 1,5,4,6,2,3 -> positions 0..5
    function automatic t_hall_pos hall_pos(input logic [2:0] code);
        t_hall_pos r;
        r.valid = 1'b1;
        unique case (code)
            3'd1:    r.pos = 3'd0;
            3'd5:    r.pos = 3'd1;
            3'd4:    r.pos = 3'd2;
            3'd6:    r.pos = 3'd3;
            3'd2:    r.pos = 3'd4;
            3'd3:    r.pos = 3'd5;
            default: begin
                r.valid = 1'b0;
                r.pos   = 3'd0;
            end
        endcase
        return r;
    endfunction

    // shortest signed step between two positions, -3..+3
    function automatic logic signed [3:0] hall_step(input logic [2:0] pos,
                                                    input logic [2:0] prev);
        logic signed [3:0] d;
        d = signed'({1'b0, pos}) - signed'({1'b0, prev});
        if (d < -4'sd2) begin
            d = d + 4'sd6;
        end else if (d > 4'sd2) begin
            d = d - 4'sd6;
        end
        return d;
    endfunction

endpackage

// ----- hdl/hall_position_speed_counter.sv -----
// After an input accept the sample is stepped and tested. A speed refresh adds the
// multiply and saturation check, then the 20-step restoring divider unless the
// speed saturates; the output beat is loaded once the output register is free.
// A new sample waits for idle; the one-bit-per-cycle divider sets the worst case.
// Reset (i_rst_n low, synchronous): counts, marks, last code and speed cleared,
// ticks_per_rotation back to 90, no output beat pending.
`include "hall_position_speed_counter_macros.svh"
module hall_position_speed_counter
    import hpsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] hall_code, [34:3] time_ms, [35] clear_count, [39:36] zero
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TPR_W-1:0]      i_cfg_data,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] position_ticks, [52:32] speed_q8, [53] speed_updated,
    // [54] code_invalid, [55] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    hpsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    hpsc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (s_axis_tdata),
        .o_out_data (m_axis_tdata)
    );

    `HPSC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    `HPSC_NEVER(a_no_accept_in_div, i_clk, i_rst_n, w_cmd.div && (s_axis_tready || o_cfg_ready))
    `HPSC_NEVER(a_invalid_no_update, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[54] && m_axis_tdata[53])

endmodule

// ----- hdl/hpsc_ctrl.sv -----
// Sequencer for the hall counter: handshakes and datapath commands.
// Depends on hpsc_pkg.
module hpsc_ctrl
    import hpsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.cfg_wr = i_cfg_valid;
                o_cmd.load   = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = ST_TEST;
            end
            ST_TEST: begin
                n_state = i_status.need_speed ? ST_MUL : ST_OUT;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = i_status.ovf ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.div_last) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // output register free or emptying this cycle
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- hdl/hpsc_datapath.sv -----
// Datapath of the hall counter: tick state, speed multipliers, serial divider.
// Depends on hpsc_pkg; driven by hpsc_ctrl commands.
module hpsc_datapath
    import hpsc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [TPR_W-1:0]      i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    logic [TPR_W-1:0]   r_tpr;
    logic [2:0]         r_in_code;
    logic [TIME_W-1:0]  r_in_time;
    logic               r_in_clear;
    logic [2:0]         r_last_code;
    logic [TICK_W-1:0]  r_tick;
    logic [TICK_W-1:0]  r_mark_ticks;
    logic [TIME_W-1:0]  r_mark_time;
    logic [SPEED_W-1:0] r_speed;
    logic               r_updated;
    logic               r_invalid;
    logic [TICK_W-1:0]  r_delta;
    logic               r_check;
    logic               r_neg;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_rem;
    logic [62:0]        r_dsh;
    logic [QUO_W-1:0]   r_quo;
    logic [CNT_W-1:0]   r_cnt;
    logic [OUT_DATA_W-1:0] r_out_data;

    // step evaluation on the latched sample
    logic [2:0]        last_eff;
    logic [TICK_W-1:0] tick_eff;
    logic [TICK_W-1:0] mark_eff;
    t_hall_pos         pos_cur;
    t_hall_pos         pos_prev;
    logic signed [3:0] step;
    logic [TICK_W-1:0] tick_new;
    logic              check_new;
    logic [TICK_W-1:0] mag;
    logic              ge;
    logic [QUO_W-1:0]  quo_final;

    always_comb begin
        last_eff  = r_in_clear ? '0 : r_last_code;
        tick_eff  = r_in_clear ? '0 : r_tick;
        mark_eff  = r_in_clear ? '0 : r_mark_ticks;
        pos_cur   = hall_pos(r_in_code);
        pos_prev  = hall_pos(last_eff);
        step      = hall_step(pos_cur.pos, pos_prev.pos);
        tick_new  = tick_eff;
        check_new = 1'b0;
        if ((r_in_code != last_eff) && pos_cur.valid) begin
            if (!pos_prev.valid) begin
                tick_new = '0;
            end else begin
                tick_new  = tick_eff + {{(TICK_W-4){step[3]}}, step};
                check_new = 1'b1;
            end
        end
    end

    assign mag       = r_delta[TICK_W-1] ? (TICK_W'(0) - r_delta) : r_delta;
    assign ge        = ({13'd0, r_rem} >= r_dsh);
    assign quo_final = {r_quo[QUO_W-2:0], ge};

    assign o_status.need_speed = r_check && (mag >= {{(TICK_W-TPR_W){1'b0}}, r_tpr});
    // quotient would reach 2^20: saturate (also catches a zero divisor)
    assign o_status.ovf        = ({14'd0, r_num} >= {r_den, 20'd0});
    assign o_status.div_last   = (r_cnt == '0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpr        <= TPR_RESET;
            r_last_code  <= '0;
            r_tick       <= '0;
            r_mark_ticks <= '0;
            r_mark_time  <= '0;
            r_speed      <= '0;
        end else begin
            if (i_cmd.cfg_wr) begin
                r_tpr <= i_cfg_data;
            end
            if (i_cmd.step) begin
                r_last_code <= r_in_code;
                r_tick      <= tick_new;
                if (r_in_clear) begin
                    r_mark_ticks <= '0;
                    r_mark_time  <= '0;
                end
            end
            if (i_cmd.mul) begin
                r_mark_ticks <= r_tick;
                r_mark_time  <= r_in_time;
            end
            if (i_cmd.sat && o_status.ovf) begin
                r_speed <= r_neg ? SPEED_NEG_SAT : SPEED_POS_SAT;
            end
            if (i_cmd.div && o_status.div_last) begin
                r_speed <= r_neg ? (SPEED_W'(0) - {1'b0, quo_final})
                                 : {1'b0, quo_final};
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_code  <= i_in_data[2:0];
            r_in_time  <= i_in_data[34:3];
            r_in_clear <= i_in_data[35];
        end
        if (i_cmd.step) begin
            r_delta   <= tick_new - mark_eff;
            r_check   <= check_new;
            r_invalid <= !pos_cur.valid;
            r_updated <= 1'b0;
        end
        if (i_cmd.mul) begin
            r_num     <= NUM_W'(mag) * NUM_W'(Q8_MS_SCALE);
            r_den     <= DEN_W'(r_tpr) * DEN_W'(r_in_time - r_mark_time);
            r_neg     <= r_delta[TICK_W-1];
            r_updated <= 1'b1;
        end
        if (i_cmd.sat) begin
            r_rem <= r_num;
            r_dsh <= {r_den, 19'd0};
            r_quo <= '0;
            r_cnt <= DIV_LAST_BIT;
        end
        if (i_cmd.div) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh[NUM_W-1:0];
            end
            r_quo <= quo_final;
            r_dsh <= r_dsh >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.out_load) begin
            r_out_data <= {1'b0, r_invalid, r_updated, r_speed, r_tick};
        end
    end

    assign o_out_data = r_out_data;

endmodule
